// ----- sv/qbgp_pkg.sv -----
// Shared types, constants, weight table and rounding helpers for the quad grid point generator.
`timescale 1ns / 1ps

package qbgp_pkg;

  localparam int MAX_GRID_SIDE = 8;
  localparam int FRAC_BITS     = 16;
  localparam int COORD_W       = 24;
  localparam int CFG_W         = 4;
  localparam int NUM_CORNERS   = 4;
  localparam int NUM_AXES      = 3;
  localparam int IDX_W         = $clog2(MAX_GRID_SIDE);
  localparam int WEIGHT_W      = FRAC_BITS;
  localparam int PROD_W        = COORD_W + FRAC_BITS + 2;

  localparam logic [FRAC_BITS:0]         ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0]   HALF = PROD_W'(1) << (FRAC_BITS - 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [WEIGHT_W-1:0]       weight_t;

  typedef struct packed {
    idx_t row;
    idx_t col;
    logic last;
  } point_tag_t;

  typedef struct packed {
    logic       valid;
    point_tag_t tag;
    weight_t    wx;
    weight_t    wy;
  } issue_t;

  // floor((k+1) * 2^FRAC_BITS / (m+1)); row is m-1, column is k
  localparam weight_t WEIGHT_TABLE [MAX_GRID_SIDE][MAX_GRID_SIDE] = '{
    '{16'd32768, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd21845, 16'd43690, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd16384, 16'd32768, 16'd49152, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd13107, 16'd26214, 16'd39321, 16'd52428, 16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd10922, 16'd21845, 16'd32768, 16'd43690, 16'd54613, 16'd0,     16'd0,     16'd0},
    '{16'd9362,  16'd18724, 16'd28086, 16'd37449, 16'd46811, 16'd56173, 16'd0,     16'd0},
    '{16'd8192,  16'd16384, 16'd24576, 16'd32768, 16'd40960, 16'd49152, 16'd57344, 16'd0},
    '{16'd7281,  16'd14563, 16'd21845, 16'd29127, 16'd36408, 16'd43690, 16'd50972, 16'd58254}
  };

  // Coordinate times an unsigned weight in [0, ONE]
  function automatic prod_t scale(input coord_t c, input logic [FRAC_BITS:0] w);
    prod_t ce;
    prod_t we;
    ce = PROD_W'(c);
    we = PROD_W'($signed({1'b0, w}));
    return ce * we;
  endfunction

  // Sum two weighted terms, round half up, shift back to Q7.16
  function automatic coord_t blend_round(input prod_t p0, input prod_t p1);
    prod_t acc;
    acc = p0 + p1 + HALF;
    return acc[FRAC_BITS +: COORD_W];
  endfunction

endpackage

// ----- sv/qbgp_sequencer.sv -----
// Quad latch, grid side register, row/column walker: one point per cycle unless stalled.
`timescale 1ns / 1ps

module qbgp_sequencer import qbgp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  coord_t           corner_in [NUM_CORNERS][NUM_AXES],
  input  logic             advance,
  output issue_t           issue,
  output coord_t           corner [NUM_CORNERS][NUM_AXES]
);

  logic [CFG_W-1:0] grid_side;
  logic [CFG_W-1:0] side_dec;
  idx_t             side_eff;
  idx_t             side_last;
  idx_t             row;
  idx_t             col;
  logic             busy;
  logic             fire;
  logic             at_last;
  logic             accept;

  always_comb begin
    side_dec = grid_side - CFG_W'(1);
    if (grid_side == '0) begin
      side_eff = '0;
    end else if (grid_side > CFG_W'(MAX_GRID_SIDE)) begin
      side_eff = IDX_W'(MAX_GRID_SIDE - 1);
    end else begin
      side_eff = side_dec[IDX_W-1:0];
    end
  end

  assign at_last  = (row == side_last) && (col == side_last);
  assign fire     = busy && advance;
  // take the next quad while its predecessor's final point goes out
  assign in_ready = advance && (!busy || at_last);
  assign accept   = in_valid && in_ready;

  assign issue.valid    = fire;
  assign issue.tag.row  = row;
  assign issue.tag.col  = col;
  assign issue.tag.last = at_last;
  assign issue.wx       = WEIGHT_TABLE[side_last][col];
  assign issue.wy       = WEIGHT_TABLE[side_last][row];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= CFG_W'(1);
    end else if (cfg_we) begin
      grid_side <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      row       <= '0;
      col       <= '0;
      side_last <= '0;
    end else if (accept) begin
      busy      <= 1'b1;
      row       <= '0;
      col       <= '0;
      side_last <= side_eff;
    end else if (fire) begin
      if (at_last) begin
        busy <= 1'b0;
        row  <= '0;
        col  <= '0;
      end else if (col == side_last) begin
        col <= '0;
        row <= row + IDX_W'(1);
      end else begin
        col <= col + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      corner <= corner_in;
    end
  end

endmodule

// ----- sv/qbgp_interp.sv -----
// Four-stage bilinear blend pipeline: x products, x blend, y products, y blend.
`timescale 1ns / 1ps

module qbgp_interp import qbgp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  issue_t     issue,
  input  coord_t     corner [NUM_CORNERS][NUM_AXES],
  output logic       advance,
  output logic       out_valid,
  input  logic       out_ready,
  output coord_t     point [NUM_AXES],
  output point_tag_t tag
);

  logic             v1, v2, v3, v4;
  point_tag_t       tag1, tag2, tag3, tag4;
  weight_t          wy1, wy2;
  prod_t            pa0 [NUM_AXES];
  prod_t            pa1 [NUM_AXES];
  prod_t            pb0 [NUM_AXES];
  prod_t            pb1 [NUM_AXES];
  coord_t           a2 [NUM_AXES];
  coord_t           b2 [NUM_AXES];
  prod_t            pp0 [NUM_AXES];
  prod_t            pp1 [NUM_AXES];
  coord_t           p4 [NUM_AXES];
  logic [FRAC_BITS:0] wx_hi, wx_lo, wy_hi, wy_lo;

  // the whole pipe holds while the output register waits
  assign advance   = !v4 || out_ready;
  assign out_valid = v4;
  assign point     = p4;
  assign tag       = tag4;

  assign wx_lo = {1'b0, issue.wx};
  assign wx_hi = ONE - wx_lo;
  assign wy_lo = {1'b0, wy2};
  assign wy_hi = ONE - wy_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= issue.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag1 <= issue.tag;
      wy1  <= issue.wy;
      tag2 <= tag1;
      wy2  <= wy1;
      tag3 <= tag2;
      tag4 <= tag3;
      for (int d = 0; d < NUM_AXES; d++) begin
        pa0[d] <= scale(corner[0][d], wx_hi);
        pa1[d] <= scale(corner[1][d], wx_lo);
        pb0[d] <= scale(corner[2][d], wx_hi);
        pb1[d] <= scale(corner[3][d], wx_lo);
        a2[d]  <= blend_round(pa0[d], pa1[d]);
        b2[d]  <= blend_round(pb0[d], pb1[d]);
        pp0[d] <= scale(a2[d], wy_hi);
        pp1[d] <= scale(b2[d], wy_lo);
        p4[d]  <= blend_round(pp0[d], pp1[d]);
      end
    end
  end

endmodule

// ----- sv/quad_bilinear_grid_point_generator.sv -----
// Top level of the quad grid point generator: sequencer plus blend pipeline.
`timescale 1ns / 1ps

// Each accepted quad (four Q7.16 corners) yields an m-by-m grid of interior
// points, row by row, at one point per cycle while the output is not stalled
// (the largest grid side is 8); the row/column walker in the sequencer issues
// the points. The next quad is accepted in the cycle its predecessor's last
// point is issued, so points stream with no gap. An issued point passes
// through two multiply and two round stages; a stalled output holds the
// whole pipeline without loss.
// grid_side is sampled when a quad is accepted; zero acts as 1 and values
// above 8 act as 8. Write it only while the block is idle.
module quad_bilinear_grid_point_generator import qbgp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  coord_t           corner0_x,
  input  coord_t           corner0_y,
  input  coord_t           corner0_z,
  input  coord_t           corner1_x,
  input  coord_t           corner1_y,
  input  coord_t           corner1_z,
  input  coord_t           corner2_x,
  input  coord_t           corner2_y,
  input  coord_t           corner2_z,
  input  coord_t           corner3_x,
  input  coord_t           corner3_y,
  input  coord_t           corner3_z,
  output logic             out_valid,
  input  logic             out_ready,
  output coord_t           point_x,
  output coord_t           point_y,
  output coord_t           point_z,
  output idx_t             grid_row,
  output idx_t             grid_col,
  output logic             last_point
);

  coord_t     corner_in [NUM_CORNERS][NUM_AXES];
  coord_t     corner [NUM_CORNERS][NUM_AXES];
  coord_t     point [NUM_AXES];
  issue_t     issue;
  point_tag_t tag;
  logic       advance;

  assign corner_in[0][0] = corner0_x;
  assign corner_in[0][1] = corner0_y;
  assign corner_in[0][2] = corner0_z;
  assign corner_in[1][0] = corner1_x;
  assign corner_in[1][1] = corner1_y;
  assign corner_in[1][2] = corner1_z;
  assign corner_in[2][0] = corner2_x;
  assign corner_in[2][1] = corner2_y;
  assign corner_in[2][2] = corner2_z;
  assign corner_in[3][0] = corner3_x;
  assign corner_in[3][1] = corner3_y;
  assign corner_in[3][2] = corner3_z;

  qbgp_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .corner_in (corner_in),
    .advance   (advance),
    .issue     (issue),
    .corner    (corner)
  );

  qbgp_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .corner    (corner),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point     (point),
    .tag       (tag)
  );

  assign point_x    = point[0];
  assign point_y    = point[1];
  assign point_z    = point[2];
  assign grid_row   = tag.row;
  assign grid_col   = tag.col;
  assign last_point = tag.last;

endmodule
